>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

>>> rtl/cmrf_pkg.sv
// ----------------------------------------------------------------------------
// cmrf_pkg
// Types, sizes and codes shared by the record filter modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cmrf_pkg;

	localparam int MAX_RECORDS  = 32;
	localparam int MAX_NAME_LEN = 31;

	localparam int CHAR_W  = 8;
	localparam int CNT_W   = 10;
	localparam int ID_W    = 32;
	localparam int DEPTH   = 1 << CHAR_W;
	localparam int REC_W   = $clog2(MAX_RECORDS + 1);
	localparam int IDX_W   = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
	localparam int NL_W    = $clog2(MAX_NAME_LEN + 1);

	localparam logic [CNT_W-1:0]       COUNT_MAX = {CNT_W{1'b1}};
	localparam logic [MAX_RECORDS-1:0] ROW_ONE   = MAX_RECORDS'(1);

	localparam logic CMD_CHAR   = 1'b0;
	localparam logic CMD_FINISH = 1'b1;
	localparam logic KIND_MODE  = 1'b0;
	localparam logic KIND_ID    = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHAR_UPD,
		ST_REPORT,
		ST_WALK,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic accept_char;
		logic fin_read;
		logic char_write;
		logic load_report;
		logic id_read;
		logic load_id;
		logic shift_row;
		logic clear;
	} dp_cmd_t;

	typedef struct packed {
		logic out_free;
		logic row_zero;
		logic row_bit0;
		logic row_rest_zero;
	} dp_stat_t;

endpackage

>>> rtl/char_mode_record_filter.sv
// ----------------------------------------------------------------------------
// char_mode_record_filter
// Character histogram with running mode and per-record membership report.
// ----------------------------------------------------------------------------
// Input words (command, first_of_record, record_id, char_code) arrive on a
// valid/ready channel. For a character word the histogram and presence entry
// are read on the accept edge and written back, with the mode compare, in
// the next cycle; in_ready is high again after that.
// A finish word starts a report on the output channel: first the mode word
// (kind 0), then one word per record holding the mode, in record order, with
// last on the final word. The mode word is loaded into the output register
// in ST_REPORT once that register is free; the walk then passes unmatched
// record slots in ST_WALK and, per matching record, reads the single-port id
// store in ST_WALK and loads the word in ST_EMIT. After the last word is
// loaded the histogram, presence rows and record count clear and the block
// takes input again. Reset clears the histogram and presence rows through
// per-entry valid bits at once; no clearing pass is needed. When out_ready
// is held low the output word holds and the walk waits at the next match.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module char_mode_record_filter (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                command,
	input  logic                                first_of_record,
	input  logic signed [cmrf_pkg::ID_W-1:0]    record_id,
	input  logic        [cmrf_pkg::CHAR_W-1:0]  char_code,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                kind,
	output logic        [cmrf_pkg::CHAR_W-1:0]  mode_char,
	output logic        [cmrf_pkg::CNT_W-1:0]   mode_count,
	output logic signed [cmrf_pkg::ID_W-1:0]    match_id,
	output logic                                last
);

	cmrf_pkg::dp_cmd_t  cmd;
	cmrf_pkg::dp_stat_t stat;

	cmrf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.command  (command),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	cmrf_datapath u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.first_of_record (first_of_record),
		.record_id       (record_id),
		.char_code       (char_code),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.kind            (kind),
		.mode_char       (mode_char),
		.mode_count      (mode_count),
		.match_id        (match_id),
		.last            (last)
	);

endmodule

>>> rtl/cmrf_ctrl.sv
// ----------------------------------------------------------------------------
// cmrf_ctrl
// Sequencer for character updates and the finish report walk.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cmrf_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                command,
	output logic                in_ready,
	input  cmrf_pkg::dp_stat_t  stat,
	output cmrf_pkg::dp_cmd_t   cmd
);

	cmrf_pkg::state_t state_q;
	cmrf_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cmrf_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			cmrf_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (command == cmrf_pkg::CMD_CHAR) begin
						cmd.accept_char = 1'b1;
						state_d         = cmrf_pkg::ST_CHAR_UPD;
					end else begin
						cmd.fin_read = 1'b1;
						state_d      = cmrf_pkg::ST_REPORT;
					end
				end
			end
			cmrf_pkg::ST_CHAR_UPD: begin
				cmd.char_write = 1'b1;
				state_d        = cmrf_pkg::ST_IDLE;
			end
			cmrf_pkg::ST_REPORT: begin
				if (stat.out_free) begin
					cmd.load_report = 1'b1;
					if (stat.row_zero) begin
						cmd.clear = 1'b1;
						state_d   = cmrf_pkg::ST_IDLE;
					end else begin
						state_d = cmrf_pkg::ST_WALK;
					end
				end
			end
			cmrf_pkg::ST_WALK: begin
				if (stat.row_bit0) begin
					cmd.id_read = 1'b1;
					state_d     = cmrf_pkg::ST_EMIT;
				end else begin
					cmd.shift_row = 1'b1;
				end
			end
			cmrf_pkg::ST_EMIT: begin
				if (stat.out_free) begin
					cmd.load_id   = 1'b1;
					cmd.shift_row = 1'b1;
					if (stat.row_rest_zero) begin
						cmd.clear = 1'b1;
						state_d   = cmrf_pkg::ST_IDLE;
					end else begin
						state_d = cmrf_pkg::ST_WALK;
					end
				end
			end
			default: begin
				state_d = cmrf_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

>>> rtl/cmrf_datapath.sv
// ----------------------------------------------------------------------------
// cmrf_datapath
// Histogram, presence rows, record ids, running mode and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cmrf_datapath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  cmrf_pkg::dp_cmd_t                   cmd,
	output cmrf_pkg::dp_stat_t                  stat,
	input  logic                                first_of_record,
	input  logic signed [cmrf_pkg::ID_W-1:0]    record_id,
	input  logic        [cmrf_pkg::CHAR_W-1:0]  char_code,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                kind,
	output logic        [cmrf_pkg::CHAR_W-1:0]  mode_char,
	output logic        [cmrf_pkg::CNT_W-1:0]   mode_count,
	output logic signed [cmrf_pkg::ID_W-1:0]    match_id,
	output logic                                last
);

	logic [cmrf_pkg::CNT_W-1:0]       cnt_mem  [cmrf_pkg::DEPTH];
	logic [cmrf_pkg::MAX_RECORDS-1:0] pres_mem [cmrf_pkg::DEPTH];
	logic [cmrf_pkg::ID_W-1:0]        id_mem   [cmrf_pkg::MAX_RECORDS];
	logic [cmrf_pkg::DEPTH-1:0]       valid_q;

	logic [cmrf_pkg::REC_W-1:0]       rc_q;
	logic                             open_q;
	logic [cmrf_pkg::NL_W-1:0]        name_len_q;
	logic [cmrf_pkg::IDX_W-1:0]       cur_bit_q;
	logic [cmrf_pkg::CHAR_W-1:0]      best_char_q;
	logic [cmrf_pkg::CNT_W-1:0]       best_count_q;

	logic                             pend_s1;
	logic [cmrf_pkg::CHAR_W-1:0]      ch_s1;
	logic [cmrf_pkg::IDX_W-1:0]       bit_s1;
	logic [cmrf_pkg::CNT_W-1:0]       cnt_rd_s1;
	logic [cmrf_pkg::MAX_RECORDS-1:0] pres_rd_s1;
	logic                             vld_s1;
	logic [cmrf_pkg::ID_W-1:0]        id_rd_s1;

	logic [cmrf_pkg::MAX_RECORDS-1:0] row_q;
	logic [cmrf_pkg::IDX_W-1:0]       idx_q;

	logic                             out_valid_q;
	logic                             kind_q;
	logic [cmrf_pkg::CHAR_W-1:0]      mode_char_q;
	logic [cmrf_pkg::CNT_W-1:0]       mode_count_q;
	logic [cmrf_pkg::ID_W-1:0]        match_id_q;
	logic                             last_q;

	logic                             room;
	logic                             open_new;
	logic [cmrf_pkg::NL_W-1:0]        nl_eff;
	logic                             count_en;
	logic [cmrf_pkg::IDX_W-1:0]       bit_new;
	logic [cmrf_pkg::CHAR_W-1:0]      rd_addr;
	logic                             rd_en;
	logic [cmrf_pkg::CNT_W-1:0]       c_old;
	logic [cmrf_pkg::CNT_W-1:0]       c_new;
	logic [cmrf_pkg::MAX_RECORDS-1:0] row_rd;
	logic [cmrf_pkg::MAX_RECORDS-1:0] row_next;
	logic                             out_load;

	assign room     = rc_q < cmrf_pkg::REC_W'(cmrf_pkg::MAX_RECORDS);
	assign open_new = first_of_record ? room : open_q;
	assign nl_eff   = first_of_record ? '0 : name_len_q;
	assign count_en = open_new && (char_code != '0)
		&& (nl_eff < cmrf_pkg::NL_W'(cmrf_pkg::MAX_NAME_LEN));
	assign bit_new  = first_of_record ? rc_q[cmrf_pkg::IDX_W-1:0] : cur_bit_q;
	assign rd_addr  = cmd.fin_read ? best_char_q : char_code;
	assign rd_en    = cmd.accept_char || cmd.fin_read;

	assign c_old    = vld_s1 ? cnt_rd_s1 : '0;
	assign c_new    = (c_old < cmrf_pkg::COUNT_MAX) ? c_old + cmrf_pkg::CNT_W'(1) : c_old;
	assign row_rd   = vld_s1 ? pres_rd_s1 : '0;
	assign row_next = row_q >> 1;
	assign out_load = cmd.load_report || cmd.load_id;

	assign stat.out_free      = !out_valid_q || out_ready;
	assign stat.row_zero      = row_rd == '0;
	assign stat.row_bit0      = row_q[0];
	assign stat.row_rest_zero = row_next == '0;

	// memories
	always_ff @(posedge clk) begin
		if (rd_en) begin
			cnt_rd_s1  <= cnt_mem[rd_addr];
			pres_rd_s1 <= pres_mem[rd_addr];
		end
		if (cmd.char_write && pend_s1) begin
			cnt_mem[ch_s1]  <= c_new;
			pres_mem[ch_s1] <= row_rd | (cmrf_pkg::ROW_ONE << bit_s1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept_char && first_of_record && room) begin
			id_mem[rc_q[cmrf_pkg::IDX_W-1:0]] <= record_id;
		end
		if (cmd.id_read) begin
			id_rd_s1 <= id_mem[idx_q];
		end
	end

	// payload captured with each character read
	always_ff @(posedge clk) begin
		if (cmd.accept_char) begin
			ch_s1  <= char_code;
			bit_s1 <= bit_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q      <= '0;
			rc_q         <= '0;
			open_q       <= 1'b0;
			name_len_q   <= '0;
			cur_bit_q    <= '0;
			best_char_q  <= '0;
			best_count_q <= '0;
			pend_s1      <= 1'b0;
			vld_s1       <= 1'b0;
			row_q        <= '0;
			idx_q        <= '0;
		end else begin
			if (rd_en) begin
				vld_s1 <= valid_q[rd_addr];
			end
			if (cmd.accept_char) begin
				pend_s1 <= count_en;
				if (first_of_record) begin
					open_q <= room;
					if (room) begin
						rc_q      <= rc_q + cmrf_pkg::REC_W'(1);
						cur_bit_q <= rc_q[cmrf_pkg::IDX_W-1:0];
					end
				end
				if (count_en) begin
					name_len_q <= nl_eff + cmrf_pkg::NL_W'(1);
				end else if (first_of_record) begin
					name_len_q <= '0;
				end
			end
			if (cmd.char_write && pend_s1) begin
				valid_q[ch_s1] <= 1'b1;
				if (c_new > best_count_q) begin
					best_char_q  <= ch_s1;
					best_count_q <= c_new;
				end
			end
			if (cmd.load_report) begin
				row_q <= row_rd;
				idx_q <= '0;
			end else if (cmd.shift_row) begin
				row_q <= row_next;
				idx_q <= idx_q + cmrf_pkg::IDX_W'(1);
			end
			if (cmd.clear) begin
				valid_q      <= '0;
				rc_q         <= '0;
				open_q       <= 1'b0;
				name_len_q   <= '0;
				best_char_q  <= '0;
				best_count_q <= '0;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			mode_char_q  <= best_char_q;
			mode_count_q <= best_count_q;
			if (cmd.load_report) begin
				kind_q     <= cmrf_pkg::KIND_MODE;
				match_id_q <= '0;
				last_q     <= row_rd == '0;
			end else begin
				kind_q     <= cmrf_pkg::KIND_ID;
				match_id_q <= id_rd_s1;
				last_q     <= row_next == '0;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign kind       = kind_q;
	assign mode_char  = mode_char_q;
	assign mode_count = mode_count_q;
	assign match_id   = match_id_q;
	assign last       = last_q;

endmodule

>>> rtl/cmrf_checker.sv
// ----------------------------------------------------------------------------
// cmrf_checker
// Port-level checks on the record filter handshakes and report sequence.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cmrf_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               in_valid,
	input logic                               in_ready,
	input logic                               out_valid,
	input logic                               out_ready,
	input logic                               kind,
	input logic signed [cmrf_pkg::ID_W-1:0]   match_id,
	input logic                               last
);

	`ASSERT_NEXT(a_in_busy_after_accept, clk, arst_n, in_valid && in_ready, !in_ready)
	`ASSERT_SAME(a_no_input_mid_report, clk, arst_n, out_valid && !last, !in_ready)
	`ASSERT_SAME(a_mode_word_no_id, clk, arst_n, out_valid && (kind == cmrf_pkg::KIND_MODE), match_id == '0)
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(match_id) && $stable(last))

endmodule

bind char_mode_record_filter cmrf_checker u_cmrf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.kind      (kind),
	.match_id  (match_id),
	.last      (last)
);
